/* src/wcl_pkg.sv */
// ----------------------------------------------------------------------------
// wcl_pkg
// Shared types, register indexes and defaults for the worker capacity ledger.
// ----------------------------------------------------------------------------
package wcl_pkg;

  localparam int APP_SLOTS_DEF  = 64;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int FIELD_BITS     = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TOTAL_WORKERS = 2'd0,
    CFG_SURGE_BUDGET  = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_FRESH   = 3'd0,
    MODE_REPLACE = 3'd1,
    MODE_COMMIT  = 3'd2,
    MODE_ABORT   = 3'd3,
    MODE_RETIRE  = 3'd4,
    MODE_RELEASE = 3'd5,
    MODE_QUERY   = 3'd6
  } mode_t;

  typedef struct packed {
    logic [2:0]            mode;
    logic [5:0]            app_id;
    logic [FIELD_BITS-1:0] req_size;
    logic [FIELD_BITS-1:0] prev_size;
    logic                  replace_flag;
  } in_item_t;

  typedef struct packed {
    logic                  accepted;
    logic [FIELD_BITS-1:0] app_steady;
    logic [FIELD_BITS-1:0] app_surge;
    logic                  app_holds;
    logic [FIELD_BITS-1:0] steady_total;
    logic [FIELD_BITS-1:0] surge_total;
    logic                  fault;
  } out_item_t;

endpackage

/* src/worker_capacity_ledger_top.sv */
// ----------------------------------------------------------------------------
// worker_capacity_ledger_top
// Admission ledger for worker capacity: per-slot steady/surge counts and
// running totals, checked against a worker ceiling and a surge budget.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+---------------------------
//  input   | in_valid / in_ready / in_data  | wcl_pkg::in_item_t
//  result  | out_valid / out_ready/out_data | wcl_pkg::out_item_t
//  config  | cfg_valid / cfg_ready          | cfg_index, cfg_data (16b)
//
//  Throughput is one transaction per cycle while results are taken. Accepting
//  an input registers the slot RAM read and the input item; the update stage
//  then registers the update, the write-back and the result as it advances.
//  Back-to-back transactions on the same slot take the write-back data
//  through a bypass register instead of the RAM read.
//  After reset a clearing pass zeroes the slot RAM, one slot per cycle, over
//  all APP_SLOTS slots; in_ready stays low during it. Config is always ready.
//  A stalled result holds the update stage, which drops in_ready.
// ----------------------------------------------------------------------------
module worker_capacity_ledger_top #(
  parameter int APP_SLOTS  = wcl_pkg::APP_SLOTS_DEF,
  parameter int COUNT_BITS = wcl_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wcl_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wcl_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wcl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [wcl_pkg::FIELD_BITS-1:0]      cfg_data
);
  import wcl_pkg::*;

  localparam int IDX_W   = $clog2(APP_SLOTS);
  localparam int ID_VALS = 64;

  // config registers
  logic [FIELD_BITS-1:0] total_workers_r, surge_budget_r;

  // clearing pass
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;

  // update stage
  logic                    s1_v_r;
  in_item_t                s1_item_r;
  logic [IDX_W-1:0]        s1_idx_r;
  logic                    byp_r;
  logic [2*COUNT_BITS-1:0] byp_data_r;
  logic [2*COUNT_BITS-1:0] ram_rdata;
  logic [2*COUNT_BITS-1:0] slot_cur;
  logic [2*COUNT_BITS-1:0] slot_new;

  // totals
  logic [COUNT_BITS-1:0] steady_sum_r, surge_sum_r;
  logic [COUNT_BITS-1:0] new_steady, new_surge, new_steady_sum, new_surge_sum;

  // result register
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t upd_result;

  logic             acc;
  logic             s1_adv;
  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] slot_lut [ID_VALS];
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [2*COUNT_BITS-1:0] ram_wdata;

  // app_id modulo APP_SLOTS as a constant lookup
  for (genvar g = 0; g < ID_VALS; g++) begin : g_slot_lut
    assign slot_lut[g] = IDX_W'(g % APP_SLOTS);
  end

  assign in_idx    = slot_lut[in_data.app_id];
  assign s1_adv    = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready  = !clr_busy_r && (!s1_v_r || s1_adv);
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // config write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_workers_r <= '0;
      surge_budget_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TOTAL_WORKERS: total_workers_r <= cfg_data;
        CFG_SURGE_BUDGET:  surge_budget_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing pass over the slot RAM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == IDX_W'(APP_SLOTS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign ram_we    = clr_busy_r || s1_adv;
  assign ram_waddr = clr_busy_r ? clr_idx_r : s1_idx_r;
  assign ram_wdata = clr_busy_r ? '0 : slot_new;

  wcl_slot_ram #(
    .DEPTH (APP_SLOTS),
    .WIDTH (2*COUNT_BITS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // input register plus write-back bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r  <= in_data;
      s1_idx_r   <= in_idx;
      byp_r      <= s1_adv && (s1_idx_r == in_idx);
      byp_data_r <= slot_new;
    end
  end

  assign slot_cur = byp_r ? byp_data_r : ram_rdata;

  wcl_update #(
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .item           (s1_item_r),
    .slot_steady    (slot_cur[2*COUNT_BITS-1:COUNT_BITS]),
    .slot_surge     (slot_cur[COUNT_BITS-1:0]),
    .steady_sum     (steady_sum_r),
    .surge_sum      (surge_sum_r),
    .total_workers  (total_workers_r),
    .surge_budget   (surge_budget_r),
    .new_steady     (new_steady),
    .new_surge      (new_surge),
    .new_steady_sum (new_steady_sum),
    .new_surge_sum  (new_surge_sum),
    .result         (upd_result)
  );

  assign slot_new = {new_steady, new_surge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steady_sum_r <= '0;
      surge_sum_r  <= '0;
    end else if (s1_adv) begin
      steady_sum_r <= new_steady_sum;
      surge_sum_r  <= new_surge_sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= upd_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // assertions
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("update stage advanced without loading a result");

  a_accept_only_reserve: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && upd_result.accepted) |->
      (s1_item_r.mode == MODE_FRESH || s1_item_r.mode == MODE_REPLACE))
    else $error("accepted flag raised on a non-reserve transaction");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_v_r && !out_valid_r))
    else $error("transaction in flight during the clearing pass");

  a_bypass_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && s1_adv && (s1_idx_r == in_idx)) |=> byp_r)
    else $error("back-to-back same-slot transaction missed the bypass");

endmodule

/* src/wcl_slot_ram.sv */
// ----------------------------------------------------------------------------
// wcl_slot_ram
// Per-slot count storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wcl_slot_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/wcl_update.sv */
// ----------------------------------------------------------------------------
// wcl_update
// Admission checks and clamped/saturating count updates for one transaction.
// ----------------------------------------------------------------------------
module wcl_update #(
  parameter int COUNT_BITS = 16
) (
  input  wcl_pkg::in_item_t                item,
  input  logic [COUNT_BITS-1:0]            slot_steady,
  input  logic [COUNT_BITS-1:0]            slot_surge,
  input  logic [COUNT_BITS-1:0]            steady_sum,
  input  logic [COUNT_BITS-1:0]            surge_sum,
  input  logic [wcl_pkg::FIELD_BITS-1:0]   total_workers,
  input  logic [wcl_pkg::FIELD_BITS-1:0]   surge_budget,
  output logic [COUNT_BITS-1:0]            new_steady,
  output logic [COUNT_BITS-1:0]            new_surge,
  output logic [COUNT_BITS-1:0]            new_steady_sum,
  output logic [COUNT_BITS-1:0]            new_surge_sum,
  output wcl_pkg::out_item_t               result
);
  import wcl_pkg::*;

  // extended width: room for any count or field plus two spare bits
  localparam int CW = COUNT_BITS;
  localparam int EW = ((CW > FIELD_BITS) ? CW : FIELD_BITS) + 2;
  localparam logic [EW-1:0] CMAX = {{(EW-CW){1'b0}}, {CW{1'b1}}};

  // {flag, value}
  function automatic logic [EW:0] sat_add(input logic [EW-1:0] a, input logic [EW-1:0] b);
    logic [EW-1:0] s;
    s = a + b;
    if (s > CMAX) begin
      return {1'b1, CMAX};
    end
    return {1'b0, s};
  endfunction

  function automatic logic [EW:0] sat_sub(input logic [EW-1:0] a, input logic [EW-1:0] b);
    if (b > a) begin
      return {1'b1, {EW{1'b0}}};
    end
    return {1'b0, a - b};
  endfunction

  logic [EW-1:0] psz_e, osz_e, tw_e, sb_e;
  logic [EW-1:0] st_e, su_e, sts_e, sus_e;
  logic [EW-1:0] base_e, peak_e;
  logic          absent;
  logic          acc;
  logic          flt;
  logic [EW:0]   t;

  assign psz_e  = EW'(item.req_size);
  assign osz_e  = EW'(item.prev_size);
  assign tw_e   = EW'(total_workers);
  assign sb_e   = EW'(surge_budget);
  assign absent = (slot_steady == '0) && (slot_surge == '0);

  // replace reserve checks
  assign base_e = (EW'(steady_sum) > EW'(slot_steady)) ?
                  (EW'(steady_sum) - EW'(slot_steady)) : '0;
  assign peak_e = (psz_e > EW'(slot_steady)) ? psz_e : EW'(slot_steady);

  always_comb begin
    st_e  = EW'(slot_steady);
    su_e  = EW'(slot_surge);
    sts_e = EW'(steady_sum);
    sus_e = EW'(surge_sum);
    acc   = 1'b0;
    flt   = 1'b0;
    t     = '0;
    case (item.mode)
      MODE_FRESH: begin
        if ((sts_e + psz_e) <= tw_e) begin
          t = sat_add(st_e, psz_e);  st_e  = t[EW-1:0]; flt = flt | t[EW];
          t = sat_add(sts_e, psz_e); sts_e = t[EW-1:0]; flt = flt | t[EW];
          acc = 1'b1;
        end
      end
      MODE_REPLACE: begin
        if ((slot_steady != '0) && ((base_e + psz_e) <= tw_e) &&
            ((sus_e + peak_e) <= sb_e)) begin
          t = sat_add(su_e, psz_e);  su_e  = t[EW-1:0]; flt = flt | t[EW];
          t = sat_add(sus_e, psz_e); sus_e = t[EW-1:0]; flt = flt | t[EW];
          acc = 1'b1;
        end
      end
      MODE_COMMIT: begin
        // each step clamps or saturates on its own, in this order
        t = sat_sub(su_e, psz_e);  su_e  = t[EW-1:0]; flt = flt | t[EW];
        t = sat_sub(sus_e, psz_e); sus_e = t[EW-1:0]; flt = flt | t[EW];
        t = sat_add('0, psz_e);    st_e  = t[EW-1:0]; flt = flt | t[EW];
        t = sat_sub(sts_e, osz_e); sts_e = t[EW-1:0]; flt = flt | t[EW];
        t = sat_add(sts_e, psz_e); sts_e = t[EW-1:0]; flt = flt | t[EW];
        t = sat_add(su_e, osz_e);  su_e  = t[EW-1:0]; flt = flt | t[EW];
        t = sat_add(sus_e, osz_e); sus_e = t[EW-1:0]; flt = flt | t[EW];
      end
      MODE_ABORT: begin
        if (!absent) begin
          if (item.replace_flag) begin
            t = sat_sub(su_e, psz_e);  su_e  = t[EW-1:0]; flt = flt | t[EW];
            t = sat_sub(sus_e, psz_e); sus_e = t[EW-1:0]; flt = flt | t[EW];
          end else begin
            t = sat_sub(st_e, psz_e);  st_e  = t[EW-1:0]; flt = flt | t[EW];
            t = sat_sub(sts_e, psz_e); sts_e = t[EW-1:0]; flt = flt | t[EW];
          end
        end
      end
      MODE_RETIRE: begin
        t = sat_sub(st_e, psz_e);  st_e  = t[EW-1:0]; flt = flt | t[EW];
        t = sat_sub(sts_e, psz_e); sts_e = t[EW-1:0]; flt = flt | t[EW];
        t = sat_add(su_e, psz_e);  su_e  = t[EW-1:0]; flt = flt | t[EW];
        t = sat_add(sus_e, psz_e); sus_e = t[EW-1:0]; flt = flt | t[EW];
      end
      MODE_RELEASE: begin
        if (!absent) begin
          t = sat_sub(su_e, psz_e);  su_e  = t[EW-1:0]; flt = flt | t[EW];
          t = sat_sub(sus_e, psz_e); sus_e = t[EW-1:0]; flt = flt | t[EW];
        end
      end
      default: begin
        // query and the unused code leave the ledger alone
      end
    endcase
  end

  assign new_steady     = st_e[CW-1:0];
  assign new_surge      = su_e[CW-1:0];
  assign new_steady_sum = sts_e[CW-1:0];
  assign new_surge_sum  = sus_e[CW-1:0];

  assign result.accepted     = acc;
  assign result.app_steady   = st_e[FIELD_BITS-1:0];
  assign result.app_surge    = su_e[FIELD_BITS-1:0];
  assign result.app_holds    = (st_e != '0);
  assign result.steady_total = sts_e[FIELD_BITS-1:0];
  assign result.surge_total  = sus_e[FIELD_BITS-1:0];
  assign result.fault        = flt;

endmodule

/* test/ledger_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledger_checker
// Watches the input, result and register channels of the worker capacity
// ledger. Keeps its own copy of the slot counts, totals and ceilings, works
// out the ledger view each accepted transaction should produce, and compares
// every returned result field by field with the oldest outstanding view.
// ----------------------------------------------------------------------------
module ledger_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  wcl_pkg::in_item_t                in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  wcl_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [wcl_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [wcl_pkg::FIELD_BITS-1:0]   cfg_data,
  output int                               outstanding,
  output int                               mismatches
);
  import wcl_pkg::*;

  localparam int CW    = COUNT_BITS_DEF;
  localparam int SLOTS = APP_SLOTS_DEF;

  logic [CW-1:0] worker_cap;
  logic [CW-1:0] surge_cap;
  logic [CW-1:0] slot_steady_m [SLOTS];
  logic [CW-1:0] slot_surge_m  [SLOTS];
  logic [CW-1:0] steady_sum_m;
  logic [CW-1:0] surge_sum_m;
  logic          op_fault;
  out_item_t     ledger_views_q[$];

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[CW]) begin
      op_fault = 1'b1;
      s = {1'b0, {CW{1'b1}}};
    end
    return s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] clamp_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
    if (b > a) begin
      op_fault = 1'b1;
      return '0;
    end
    return a - b;
  endfunction

  // Apply one operation to the local ledger and return the view it leaves.
  function automatic out_item_t post_op_view(input in_item_t op);
    logic [5:0]    s;
    logic [CW-1:0] psz;
    logic [CW-1:0] osz;
    logic [CW-1:0] old;
    logic [CW-1:0] base;
    logic [CW-1:0] peak;
    logic [CW:0]   need_steady;
    logic [CW:0]   need_surge;
    logic          absent;
    logic          acc;
    out_item_t     view;
    s        = op.app_id;
    psz      = op.req_size;
    osz      = op.prev_size;
    acc      = 1'b0;
    op_fault = 1'b0;
    absent   = (slot_steady_m[s] == '0) && (slot_surge_m[s] == '0);
    case (op.mode)
      MODE_FRESH: begin
        need_steady = {1'b0, steady_sum_m} + {1'b0, psz};
        if (need_steady <= {1'b0, worker_cap}) begin
          slot_steady_m[s] = sat_add(slot_steady_m[s], psz);
          steady_sum_m     = sat_add(steady_sum_m, psz);
          acc              = 1'b1;
        end
      end
      MODE_REPLACE: begin
        old = slot_steady_m[s];
        // Steady check only: a short sum floors at zero without a fault.
        base        = (steady_sum_m > old) ? steady_sum_m - old : '0;
        peak        = (psz > old) ? psz : old;
        need_steady = {1'b0, base} + {1'b0, psz};
        need_surge  = {1'b0, surge_sum_m} + {1'b0, peak};
        if (old != '0 && need_steady <= {1'b0, worker_cap} &&
            need_surge <= {1'b0, surge_cap}) begin
          slot_surge_m[s] = sat_add(slot_surge_m[s], psz);
          surge_sum_m     = sat_add(surge_sum_m, psz);
          acc             = 1'b1;
        end
      end
      MODE_COMMIT: begin
        slot_surge_m[s]  = clamp_sub(slot_surge_m[s], psz);
        surge_sum_m      = clamp_sub(surge_sum_m, psz);
        slot_steady_m[s] = sat_add('0, psz);
        steady_sum_m     = clamp_sub(steady_sum_m, osz);
        steady_sum_m     = sat_add(steady_sum_m, psz);
        slot_surge_m[s]  = sat_add(slot_surge_m[s], osz);
        surge_sum_m      = sat_add(surge_sum_m, osz);
      end
      MODE_ABORT: begin
        if (!absent) begin
          if (op.replace_flag) begin
            slot_surge_m[s] = clamp_sub(slot_surge_m[s], psz);
            surge_sum_m     = clamp_sub(surge_sum_m, psz);
          end else begin
            slot_steady_m[s] = clamp_sub(slot_steady_m[s], psz);
            steady_sum_m     = clamp_sub(steady_sum_m, psz);
          end
        end
      end
      MODE_RETIRE: begin
        slot_steady_m[s] = clamp_sub(slot_steady_m[s], psz);
        steady_sum_m     = clamp_sub(steady_sum_m, psz);
        slot_surge_m[s]  = sat_add(slot_surge_m[s], psz);
        surge_sum_m      = sat_add(surge_sum_m, psz);
      end
      MODE_RELEASE: begin
        if (!absent) begin
          slot_surge_m[s] = clamp_sub(slot_surge_m[s], psz);
          surge_sum_m     = clamp_sub(surge_sum_m, psz);
        end
      end
      default: begin
      end
    endcase
    view.accepted     = acc;
    view.app_steady   = slot_steady_m[s];
    view.app_surge    = slot_surge_m[s];
    view.app_holds    = (slot_steady_m[s] != '0);
    view.steady_total = steady_sum_m;
    view.surge_total  = surge_sum_m;
    view.fault        = op_fault;
    return view;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] seen,
                                 input logic [31:0] want);
    $display("%0t ledger mismatch on %s: got %0h, expected %0h", $time, field, seen, want);
    mismatches++;
  endtask

  task automatic check_view(input out_item_t seen, input out_item_t want);
    if (seen.accepted !== want.accepted)
      report_mismatch("accepted", 32'(seen.accepted), 32'(want.accepted));
    if (seen.app_steady !== want.app_steady)
      report_mismatch("app_steady", 32'(seen.app_steady), 32'(want.app_steady));
    if (seen.app_surge !== want.app_surge)
      report_mismatch("app_surge", 32'(seen.app_surge), 32'(want.app_surge));
    if (seen.app_holds !== want.app_holds)
      report_mismatch("app_holds", 32'(seen.app_holds), 32'(want.app_holds));
    if (seen.steady_total !== want.steady_total)
      report_mismatch("steady_total", 32'(seen.steady_total), 32'(want.steady_total));
    if (seen.surge_total !== want.surge_total)
      report_mismatch("surge_total", 32'(seen.surge_total), 32'(want.surge_total));
    if (seen.fault !== want.fault)
      report_mismatch("fault", 32'(seen.fault), 32'(want.fault));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_steady_m[i] = '0;
        slot_surge_m[i]  = '0;
      end
      steady_sum_m = '0;
      surge_sum_m  = '0;
      worker_cap   = '0;
      surge_cap    = '0;
      ledger_views_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TOTAL_WORKERS: worker_cap = cfg_data;
          CFG_SURGE_BUDGET:  surge_cap  = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready)
        ledger_views_q.push_back(post_op_view(in_data));
      if (out_valid && out_ready) begin
        if (ledger_views_q.size() == 0)
          report_mismatch("unexpected result", 32'(out_data.app_steady), '0);
        else
          check_view(out_data, ledger_views_q.pop_front());
      end
    end
    outstanding <= ledger_views_q.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the worker capacity ledger through a directed pass over the special
// cases and then through phases of random reserve/replace/commit/retire/
// release sequences under several ceilings, with random idling on both sides.
// The checker beside the block predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb;
  import wcl_pkg::*;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int         SLOTS       = APP_SLOTS_DEF;

  typedef enum logic [1:0] {SLOT_FREE, SLOT_HELD, SLOT_SWAP, SLOT_DRAIN} plan_t;

  logic                    clk;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  in_item_t                in_data   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b1;
  out_item_t               out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [FIELD_BITS-1:0]   cfg_data  = '0;
  int                      outstanding;
  int                      mismatches;

  logic        idle_on    = 1'b1;
  int unsigned stall_left = 0;
  int unsigned size_cap   = 100;
  plan_t       plan_stage  [SLOTS];
  logic [15:0] plan_steady [SLOTS];
  logic [15:0] plan_extra  [SLOTS];

  worker_capacity_ledger_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ledger_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Result side back-pressure: out_ready drops at random while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 17);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [15:0] rand_u16();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return rand_u16();
      default: return 16'($urandom_range(1, size_cap));
    endcase
  endfunction

  task automatic send_op(input logic [2:0] mode, input logic [5:0] slot,
                         input logic [15:0] psz, input logic [15:0] osz, input logic flag);
    in_item_t op;
    op.mode         = mode;
    op.app_id       = slot;
    op.req_size     = psz;
    op.prev_size    = osz;
    op.replace_flag = flag;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the sender until every outstanding result has returned.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] total, input logic [15:0] budget);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TOTAL_WORKERS;
    cfg_data  <= total;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_SURGE_BUDGET;
    cfg_data  <= budget;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Advance one slot through reserve, swap, commit, retire and drain, with
  // some noise transactions mixed in to break the sequences.
  task automatic plan_step();
    logic [5:0]  s;
    logic [15:0] n;
    logic [15:0] tmp;
    int unsigned r;
    s = 6'($urandom_range(0, SLOTS - 1));
    r = $urandom_range(0, 9);
    if ($urandom_range(0, 4) == 0) begin
      send_op(3'($urandom_range(0, 7)), s, pick_size(), rand_u16(), rand_bit());
    end else begin
      case (plan_stage[s])
        SLOT_FREE: begin
          n = pick_size();
          send_op(MODE_FRESH, s, n, rand_u16(), rand_bit());
          plan_steady[s] = n;
          plan_stage[s]  = SLOT_HELD;
        end
        SLOT_HELD: begin
          if (r < 5) begin
            n = pick_size();
            send_op(MODE_REPLACE, s, n, rand_u16(), rand_bit());
            plan_extra[s] = n;
            plan_stage[s] = SLOT_SWAP;
          end else if (r < 7) begin
            send_op(MODE_RETIRE, s, plan_steady[s], rand_u16(), rand_bit());
            plan_extra[s]  = plan_steady[s];
            plan_steady[s] = '0;
            plan_stage[s]  = SLOT_DRAIN;
          end else if (r < 8) begin
            send_op(MODE_ABORT, s, plan_steady[s], rand_u16(), 1'b0);
            plan_steady[s] = '0;
            plan_stage[s]  = SLOT_FREE;
          end else begin
            send_op(MODE_QUERY, s, pick_size(), rand_u16(), rand_bit());
          end
        end
        SLOT_SWAP: begin
          if (r < 7) begin
            send_op(MODE_COMMIT, s, plan_extra[s], plan_steady[s], rand_bit());
            tmp            = plan_steady[s];
            plan_steady[s] = plan_extra[s];
            plan_extra[s]  = tmp;
            plan_stage[s]  = SLOT_DRAIN;
          end else begin
            send_op(MODE_ABORT, s, plan_extra[s], rand_u16(), 1'b1);
            plan_stage[s] = SLOT_HELD;
          end
        end
        default: begin
          send_op(MODE_RELEASE, s, plan_extra[s], rand_u16(), rand_bit());
          plan_stage[s] = (plan_steady[s] != '0) ? SLOT_HELD : SLOT_FREE;
        end
      endcase
    end
  endtask

  task automatic run_phase(input logic [15:0] total, input logic [15:0] budget,
                           input int unsigned cap, input int count, input logic idle);
    wait_drained();
    configure(total, budget);
    size_cap = cap;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0)
        idle_on <= idle && ($urandom_range(0, 3) != 0);
      if (i == count / 2)
        wait_drained();
      plan_step();
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      plan_stage[i]  = SLOT_FREE;
      plan_steady[i] = '0;
      plan_extra[i]  = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    configure(16'd1000, 16'd500);
    send_op(MODE_QUERY,   6'd0,  16'd0,     16'd0,     1'b0);
    // Absent slot: abort and release leave it alone; replace is refused.
    send_op(MODE_ABORT,   6'd5,  16'd10,    16'd0,     1'b0);
    send_op(MODE_RELEASE, 6'd5,  16'd10,    16'd0,     1'b0);
    send_op(MODE_REPLACE, 6'd5,  16'd10,    16'd0,     1'b0);
    send_op(MODE_FRESH,   6'd1,  16'd400,   16'd0,     1'b0);
    send_op(MODE_FRESH,   6'd2,  16'd700,   16'd0,     1'b0);
    send_op(MODE_FRESH,   6'd2,  16'd600,   16'd0,     1'b0);
    send_op(MODE_REPLACE, 6'd1,  16'd300,   16'd0,     1'b0);
    send_op(MODE_REPLACE, 6'd2,  16'd300,   16'd0,     1'b0);
    send_op(MODE_COMMIT,  6'd1,  16'd300,   16'd400,   1'b0);
    send_op(MODE_RELEASE, 6'd1,  16'd400,   16'd0,     1'b0);
    send_op(MODE_RETIRE,  6'd2,  16'd600,   16'd0,     1'b0);
    send_op(MODE_RELEASE, 6'd2,  16'd600,   16'd0,     1'b0);
    // Commit with an oversized old pool leaves the steady sum below a slot.
    send_op(MODE_FRESH,   6'd3,  16'd100,   16'd0,     1'b0);
    send_op(MODE_COMMIT,  6'd3,  16'd100,   16'd2000,  1'b0);
    send_op(MODE_RELEASE, 6'd3,  16'd2000,  16'd0,     1'b0);
    send_op(MODE_REPLACE, 6'd1,  16'd50,    16'd0,     1'b0);
    send_op(MODE_ABORT,   6'd1,  16'd50,    16'd0,     1'b1);
    send_op(MODE_ABORT,   6'd1,  16'd1000,  16'd0,     1'b0);
    send_op(MODE_RETIRE,  6'd7,  16'd5,     16'd0,     1'b0);
    send_op(MODE_COMMIT,  6'd8,  16'hFFFF,  16'd0,     1'b0);
    send_op(MODE_FRESH,   6'd9,  16'hFFFF,  16'd0,     1'b0);
    send_op(MODE_UNUSED,  6'd63, 16'hFFFF,  16'hFFFF,  1'b1);
    send_op(MODE_RELEASE, 6'd7,  16'hFFFF,  16'hFFFF,  1'b0);
    send_op(MODE_QUERY,   6'd8,  16'd0,     16'd0,     1'b1);

    run_phase(16'd0, 16'd0, 50, 150, 1'b1);
    run_phase(16'hFFFF, 16'hFFFF, 2000, 300, 1'b1);
    run_phase(16'($urandom_range(2000, 8000)), 16'($urandom_range(500, 4000)), 150, 400,
              1'b1);
    run_phase(rand_u16(), rand_u16(), 3000, 200, 1'b1);
    run_phase(16'd6000, 16'd3000, 150, 250, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
src/wcl_pkg.sv
src/wcl_slot_ram.sv
src/wcl_update.sv
src/worker_capacity_ledger_top.sv
test/ledger_checker.sv
test/tb.sv
